[rtl/sdtq_pkg.sv]
// Package with the constants, codes and types of the sorted deadline timer queue.
package sdtq_pkg;

   localparam int DEPTH     = 16;
   localparam int TIME_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int OCC_BITS  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_ADJUST = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_TICK   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic {
      KIND_STATUS  = 1'b0,
      KIND_EXPIRED = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0]           id;
      logic [TIME_BITS-1:0] expiry;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_RD,
      S_FIND_CHK,
      S_POS_RD,
      S_POS_CHK,
      S_RM_STEP,
      S_RM_WR,
      S_INS_STEP,
      S_INS_WR,
      S_TICK_RD,
      S_TICK_CHK,
      S_TICK_END,
      S_RESP
   } state_type;

endpackage

[rtl/sdtq_req_if.sv]
// Request channel of the sorted deadline timer queue.
interface sdtq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  timer_id;
   logic [31:0] expire_time;
   logic [31:0] current_time;

   modport source (output valid, command, timer_id, expire_time, current_time, input ready);
   modport sink (input valid, command, timer_id, expire_time, current_time, output ready);
endinterface

[rtl/sdtq_rsp_if.sv]
// Result channel of the sorted deadline timer queue.
interface sdtq_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [1:0]  status;
   logic [7:0]  reported_id;
   logic [31:0] reported_expire;
   logic        last;

   modport source (output valid, result_kind, status, reported_id, reported_expire, last,
                   input ready);
   modport sink (input valid, result_kind, status, reported_id, reported_expire, last,
                 output ready);
endinterface

[rtl/sorted_deadline_timer_queue_top.sv]
// Sorted deadline timer queue: a sorted list of timers held in one memory.
//
//   channel  direction  carries
//   req      in         command, timer_id, expire_time, current_time
//   rsp      out        result_kind, status, reported_id, reported_expire, last
//
// Every list step is a memory read and a use of its registered data, so a search
// visits the slots one at a time and a shift moves them one at a time.
// Reset empties the queue at once; the memory itself is not cleared.
// A result waits in an output register; a new request is taken while it waits, and the
// sequencer stalls only when it must load the next result into that busy register.
module sorted_deadline_timer_queue_top (
   input  logic       clock,
   input  logic       reset,
   sdtq_req_if.sink   req,
   sdtq_rsp_if.source rsp
);

   localparam int TB = sdtq_pkg::TIME_BITS;
   localparam int IB = sdtq_pkg::IDX_BITS;
   localparam int OB = sdtq_pkg::OCC_BITS;
   localparam logic [OB-1:0] FULL_COUNT = OB'(sdtq_pkg::DEPTH);

   sdtq_pkg::entry_type mem [sdtq_pkg::DEPTH];
   sdtq_pkg::entry_type rd_ff;
   logic [IB-1:0]       rd_addr;
   logic                wr_en;
   logic [IB-1:0]       wr_addr;
   sdtq_pkg::entry_type wr_data;

   sdtq_pkg::state_type   state_ff, state_in;
   sdtq_pkg::command_type cmd_ff, cmd_in;
   logic [7:0]    id_ff, id_in;
   logic [TB-1:0] exp_ff, exp_in;
   logic [TB-1:0] now_ff, now_in;
   logic [OB-1:0] idx_ff, idx_in;
   logic [OB-1:0] pos_ff, pos_in;
   logic [OB-1:0] occ_ff, occ_in;
   sdtq_pkg::status_type res_status_ff, res_status_in;
   logic [TB-1:0] res_exp_ff, res_exp_in;
   logic          pend_valid_ff, pend_valid_in;
   sdtq_pkg::entry_type pend_ff, pend_in;

   logic          out_valid_ff, out_valid_in;
   logic          out_kind_ff, out_kind_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [7:0]    out_id_ff, out_id_in;
   logic [TB-1:0] out_exp_ff, out_exp_in;
   logic          out_last_ff, out_last_in;
   logic          load;
   logic [OB-1:0] idx_next;
   logic [OB-1:0] idx_prev;

   assign idx_next = idx_ff + OB'(1);
   assign idx_prev = idx_ff - OB'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_exp_in    = res_exp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rd_addr       = idx_ff[IB-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IB-1:0];
      wr_data       = rd_ff;
      load          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      out_exp_in    = out_exp_ff;
      out_last_in   = out_last_ff;
      req.ready     = 1'b0;

      unique case (state_ff)
         sdtq_pkg::S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd_in = sdtq_pkg::command_type'(req.command);
               id_in  = req.timer_id;
               exp_in = req.expire_time[TB-1:0];
               now_in = req.current_time[TB-1:0];
               idx_in = '0;
               if (sdtq_pkg::command_type'(req.command) == sdtq_pkg::CMD_TICK) begin
                  state_in = sdtq_pkg::S_TICK_RD;
               end else begin
                  state_in = sdtq_pkg::S_FIND_RD;
               end
            end
         end
         sdtq_pkg::S_FIND_RD: begin
            if (idx_ff == occ_ff) begin
               res_exp_in = exp_ff;
               if (cmd_ff == sdtq_pkg::CMD_ADD) begin
                  if (occ_ff == FULL_COUNT) begin
                     res_status_in = sdtq_pkg::STATUS_FULL;
                     state_in      = sdtq_pkg::S_RESP;
                  end else begin
                     idx_in   = '0;
                     state_in = sdtq_pkg::S_POS_RD;
                  end
               end else begin
                  res_status_in = sdtq_pkg::STATUS_NOT_FOUND;
                  if (cmd_ff == sdtq_pkg::CMD_DELETE) begin
                     res_exp_in = '0;
                  end
                  state_in = sdtq_pkg::S_RESP;
               end
            end else begin
               state_in = sdtq_pkg::S_FIND_CHK;
            end
         end
         sdtq_pkg::S_FIND_CHK: begin
            if (rd_ff.id == id_ff) begin
               if (cmd_ff == sdtq_pkg::CMD_ADD) begin
                  res_status_in = sdtq_pkg::STATUS_DUPLICATE;
                  res_exp_in    = exp_ff;
                  state_in      = sdtq_pkg::S_RESP;
               end else begin
                  res_exp_in = rd_ff.expiry;
                  state_in   = sdtq_pkg::S_RM_STEP;
               end
            end else begin
               idx_in   = idx_next;
               state_in = sdtq_pkg::S_FIND_RD;
            end
         end
         sdtq_pkg::S_POS_RD: begin
            if (idx_ff == occ_ff) begin
               pos_in   = occ_ff;
               state_in = sdtq_pkg::S_INS_STEP;
            end else begin
               state_in = sdtq_pkg::S_POS_CHK;
            end
         end
         sdtq_pkg::S_POS_CHK: begin
            if (rd_ff.expiry <= exp_ff) begin
               idx_in   = idx_next;
               state_in = sdtq_pkg::S_POS_RD;
            end else begin
               pos_in   = idx_ff;
               idx_in   = occ_ff;
               state_in = sdtq_pkg::S_INS_STEP;
            end
         end
         sdtq_pkg::S_RM_STEP: begin
            // Slots above the removed one move down one place.
            rd_addr = idx_next[IB-1:0];
            if (idx_next >= occ_ff) begin
               occ_in = occ_ff - OB'(1);
               idx_in = '0;
               unique case (cmd_ff)
                  sdtq_pkg::CMD_ADJUST: state_in = sdtq_pkg::S_POS_RD;
                  sdtq_pkg::CMD_TICK:   state_in = sdtq_pkg::S_TICK_RD;
                  default: begin
                     res_status_in = sdtq_pkg::STATUS_OK;
                     state_in      = sdtq_pkg::S_RESP;
                  end
               endcase
               if (cmd_ff == sdtq_pkg::CMD_ADJUST) begin
                  res_exp_in = exp_ff;
               end
            end else begin
               state_in = sdtq_pkg::S_RM_WR;
            end
         end
         sdtq_pkg::S_RM_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_next;
            state_in = sdtq_pkg::S_RM_STEP;
         end
         sdtq_pkg::S_INS_STEP: begin
            // Slots from the insertion point up move one place, top first.
            rd_addr = idx_prev[IB-1:0];
            if (idx_ff == pos_ff) begin
               wr_en          = 1'b1;
               wr_data.id     = id_ff;
               wr_data.expiry = exp_ff;
               occ_in         = occ_ff + OB'(1);
               res_status_in  = sdtq_pkg::STATUS_OK;
               res_exp_in     = exp_ff;
               state_in       = sdtq_pkg::S_RESP;
            end else begin
               state_in = sdtq_pkg::S_INS_WR;
            end
         end
         sdtq_pkg::S_INS_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_prev;
            state_in = sdtq_pkg::S_INS_STEP;
         end
         sdtq_pkg::S_TICK_RD: begin
            idx_in = '0;
            if (occ_ff == '0) begin
               state_in = sdtq_pkg::S_TICK_END;
            end else begin
               state_in = sdtq_pkg::S_TICK_CHK;
            end
         end
         sdtq_pkg::S_TICK_CHK: begin
            // The previous expired timer is held back until it is known whether it is last.
            if (rd_ff.expiry <= now_ff) begin
               if (!(pend_valid_ff && out_valid_ff)) begin
                  if (pend_valid_ff) begin
                     load          = 1'b1;
                     out_kind_in   = sdtq_pkg::KIND_EXPIRED;
                     out_status_in = sdtq_pkg::STATUS_OK;
                     out_id_in     = pend_ff.id;
                     out_exp_in    = pend_ff.expiry;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = rd_ff;
                  state_in      = sdtq_pkg::S_RM_STEP;
               end
            end else begin
               state_in = sdtq_pkg::S_TICK_END;
            end
         end
         sdtq_pkg::S_TICK_END: begin
            if (!pend_valid_ff) begin
               state_in = sdtq_pkg::S_IDLE;
            end else if (!out_valid_ff) begin
               load          = 1'b1;
               out_kind_in   = sdtq_pkg::KIND_EXPIRED;
               out_status_in = sdtq_pkg::STATUS_OK;
               out_id_in     = pend_ff.id;
               out_exp_in    = pend_ff.expiry;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = sdtq_pkg::S_IDLE;
            end
         end
         sdtq_pkg::S_RESP: begin
            if (!out_valid_ff) begin
               load          = 1'b1;
               out_kind_in   = sdtq_pkg::KIND_STATUS;
               out_status_in = res_status_ff;
               out_id_in     = id_ff;
               out_exp_in    = res_exp_ff;
               out_last_in   = 1'b1;
               state_in      = sdtq_pkg::S_IDLE;
            end
         end
         default: state_in = sdtq_pkg::S_IDLE;
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sdtq_pkg::S_IDLE;
         occ_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      exp_ff        <= exp_in;
      now_ff        <= now_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_exp_ff    <= res_exp_in;
      pend_ff       <= pend_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_exp_ff    <= out_exp_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.result_kind     = out_kind_ff;
   assign rsp.status          = out_status_ff;
   assign rsp.reported_id     = out_id_ff;
   assign rsp.reported_expire = 32'(out_exp_ff);
   assign rsp.last            = out_last_ff;

endmodule

[sim/tb_sorted_deadline_timer_queue_top.sv]
// Self-checking testbench for the sorted deadline timer queue.
`timescale 1ns / 100ps

module tb_sorted_deadline_timer_queue_top;

   typedef struct packed {
      sdtq_pkg::command_type command;
      logic [7:0]            timer_id;
      logic [31:0]           expire_time;
      logic [31:0]           current_time;
   } request_type;

   typedef struct packed {
      sdtq_pkg::kind_type   result_kind;
      sdtq_pkg::status_type status;
      logic [7:0]           reported_id;
      logic [31:0]          reported_expire;
      logic                 last;
   } result_type;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdtq_req_if req ();
   sdtq_rsp_if rsp ();

   sorted_deadline_timer_queue_top uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always #1 clock = ~clock;

   request_type pending_requests[$];
   result_type  expected_results[$];

   // Shadow copy of the timer list, in queue order.
   logic [7:0]  shadow_ids[$];
   logic [31:0] shadow_expiry[$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_count = 0;
   int  hold_request = 0;
   bit  hold_done = 1'b0;
   bit  pause_request = 1'b0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   function automatic int find_timer(logic [7:0] id);
      for (int i = 0; i < shadow_ids.size(); i++)
         if (shadow_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic void place_timer(logic [7:0] id, logic [31:0] expiry);
      int pos;
      pos = 0;
      while (pos < shadow_ids.size() && shadow_expiry[pos] <= expiry) pos++;
      shadow_ids.insert(pos, id);
      shadow_expiry.insert(pos, expiry);
   endfunction

   function automatic result_type make_status(sdtq_pkg::status_type st, logic [7:0] id,
                                              logic [31:0] expiry);
      result_type r;
      r.result_kind = sdtq_pkg::KIND_STATUS;
      r.status = st;
      r.reported_id = id;
      r.reported_expire = expiry;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void predict_timer_results(request_type rq);
      int pos;
      result_type r;
      unique case (rq.command)
         sdtq_pkg::CMD_ADD: begin
            if (find_timer(rq.timer_id) >= 0) begin
               expected_results.push_back(make_status(sdtq_pkg::STATUS_DUPLICATE,
                                                      rq.timer_id, rq.expire_time));
            end else if (shadow_ids.size() >= sdtq_pkg::DEPTH) begin
               expected_results.push_back(make_status(sdtq_pkg::STATUS_FULL, rq.timer_id,
                                                      rq.expire_time));
            end else begin
               place_timer(rq.timer_id, rq.expire_time);
               expected_results.push_back(make_status(sdtq_pkg::STATUS_OK, rq.timer_id,
                                                      rq.expire_time));
            end
         end
         sdtq_pkg::CMD_ADJUST: begin
            pos = find_timer(rq.timer_id);
            if (pos < 0) begin
               expected_results.push_back(make_status(sdtq_pkg::STATUS_NOT_FOUND,
                                                      rq.timer_id, rq.expire_time));
            end else begin
               shadow_ids.delete(pos);
               shadow_expiry.delete(pos);
               place_timer(rq.timer_id, rq.expire_time);
               expected_results.push_back(make_status(sdtq_pkg::STATUS_OK, rq.timer_id,
                                                      rq.expire_time));
            end
         end
         sdtq_pkg::CMD_DELETE: begin
            pos = find_timer(rq.timer_id);
            if (pos < 0) begin
               expected_results.push_back(make_status(sdtq_pkg::STATUS_NOT_FOUND,
                                                      rq.timer_id, '0));
            end else begin
               expected_results.push_back(make_status(sdtq_pkg::STATUS_OK, rq.timer_id,
                                                      shadow_expiry[pos]));
               shadow_ids.delete(pos);
               shadow_expiry.delete(pos);
            end
         end
         default: begin
            while (shadow_ids.size() > 0 && shadow_expiry[0] <= rq.current_time) begin
               r.result_kind = sdtq_pkg::KIND_EXPIRED;
               r.status = sdtq_pkg::STATUS_OK;
               r.reported_id = shadow_ids.pop_front();
               r.reported_expire = shadow_expiry.pop_front();
               r.last = (shadow_ids.size() == 0 || shadow_expiry[0] > rq.current_time);
               expected_results.push_back(r);
            end
         end
      endcase
   endfunction

   // Driver: one request at a time from the pending queue, with a random gap after each.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.command <= sdtq_pkg::CMD_ADD;
         req.timer_id <= '0;
         req.expire_time <= '0;
         req.current_time <= '0;
      end else if (req.valid && !req_taken) begin
         // Hold the offered request until it is taken.
      end else if (pause_request) begin
         req.valid <= 1'b0;
      end else if (send_gap > 0) begin
         req.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_requests.size() > 0) begin
         req.valid <= 1'b1;
         {req.command, req.timer_id, req.expire_time, req.current_time} <=
            pending_requests.pop_front();
         send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Receiver ready: random stalls, plus a long hold-off when asked.
   always @(negedge clock) begin
      int gap;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_request > 0 && !hold_done) begin
         rsp.ready <= 1'b0;
         hold_count <= hold_request;
         hold_done <= 1'b1;
      end else if (hold_count > 0) begin
         rsp.ready <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (rsp_taken) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
         rsp.ready <= (gap == 0);
         recv_gap <= gap;
      end else if (recv_gap > 0) begin
         rsp.ready <= (recv_gap == 1);
         recv_gap <= recv_gap - 1;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Monitor: predict on accepted requests, compare accepted results.
   always @(posedge clock) begin
      result_type got, want;
      req_taken <= !reset && req.valid && req.ready;
      rsp_taken <= !reset && rsp.valid && rsp.ready;
      if (!reset) begin
         if (req.valid && req.ready)
            predict_timer_results({sdtq_pkg::command_type'(req.command), req.timer_id,
                                   req.expire_time, req.current_time});
         if (rsp.valid && rsp.ready) begin
            got = {sdtq_pkg::kind_type'(rsp.result_kind),
                   sdtq_pkg::status_type'(rsp.status), rsp.reported_id,
                   rsp.reported_expire, rsp.last};
            if (expected_results.size() == 0) begin
               $error("unexpected result: id %0d kind %0d", got.reported_id, got.result_kind);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.result_kind !== want.result_kind) begin
                  $error("result_kind: expected %0d, got %0d", want.result_kind,
                         got.result_kind);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.reported_id !== want.reported_id) begin
                  $error("reported_id: expected %0d, got %0d", want.reported_id,
                         got.reported_id);
                  error_count++;
               end
               if (got.reported_expire !== want.reported_expire) begin
                  $error("reported_expire: expected %0h, got %0h", want.reported_expire,
                         got.reported_expire);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  error_count++;
               end
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("** sorted_deadline_timer_queue_top: FAILED **");
            $finish;
         end
      end
   end

   function automatic void queue_request(sdtq_pkg::command_type cmd, logic [7:0] id,
                                         logic [31:0] expiry, logic [31:0] now);
      pending_requests.push_back({cmd, id, expiry, now});
   endfunction

   function automatic logic [31:0] random_time();
      unique case ($urandom_range(0, 3))
         0: return $urandom_range(0, 40);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-queue cases, fill past full, ties, adjusts both ways, ticks.
      queue_request(sdtq_pkg::CMD_TICK, 8'h00, '0, 32'hFFFF_FFFF);
      queue_request(sdtq_pkg::CMD_DELETE, 8'hFF, '0, '0);
      queue_request(sdtq_pkg::CMD_ADJUST, 8'h00, 32'h5, '0);
      for (int i = 0; i < sdtq_pkg::DEPTH; i++)
         queue_request(sdtq_pkg::CMD_ADD, (i == 0) ? 8'hFF : 8'(i),
                       (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i % 4), '0);
      queue_request(sdtq_pkg::CMD_ADD, 8'h80, 32'h10, '0);
      queue_request(sdtq_pkg::CMD_ADD, 8'h03, 32'h0, '0);
      queue_request(sdtq_pkg::CMD_ADJUST, 8'hFF, 32'h0, '0);
      queue_request(sdtq_pkg::CMD_ADJUST, 8'h01, 32'hFFFF_FFFE, '0);
      queue_request(sdtq_pkg::CMD_TICK, 8'h00, '0, 32'h2);

      // Random: mixed operations, mostly on ids 0 to 23 and some on any id.
      for (int n = 0; n < 220; n++) begin
         int pick;
         logic [7:0] id;
         pick = $urandom_range(0, 9);
         id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
         if (pick < 4) queue_request(sdtq_pkg::CMD_ADD, id, random_time(), $urandom);
         else if (pick < 6) queue_request(sdtq_pkg::CMD_ADJUST, id, random_time(), $urandom);
         else if (pick < 8) queue_request(sdtq_pkg::CMD_DELETE, id, $urandom, $urandom);
         else queue_request(sdtq_pkg::CMD_TICK, id, $urandom, random_time());
      end

      // Long receiver hold-off while requests keep coming, then a full drain.
      hold_request <= 600;
      while (pending_requests.size() > 140) @(posedge clock);
      pause_request <= 1'b1;
      while (req.valid || expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      pause_request <= 1'b0;
      while (pending_requests.size() > 0 || req.valid) @(posedge clock);
      // Clear out whatever is left.
      queue_request(sdtq_pkg::CMD_TICK, 8'h00, '0, 32'hFFFF_FFFF);
      while (pending_requests.size() > 0 || req.valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("** sorted_deadline_timer_queue_top: PASSED **");
      else
         $display("** sorted_deadline_timer_queue_top: FAILED **");
      $finish;
   end

endmodule
